// ===== sv/dynamic_matrix_control_step_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the dynamic matrix control step
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef DYNAMIC_MATRIX_CONTROL_STEP_MACROS_SVH
`define DYNAMIC_MATRIX_CONTROL_STEP_MACROS_SVH

// Consequent holds in the same cycle as the antecedent.
`define DMC_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define DMC_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/dmc_pkg.sv =====
// ----------------------------------------------------------------------------
// dmc_pkg
// Types, codes and helpers shared by the control step controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package dmc_pkg;

	localparam int HORIZON_MAX_DEF   = 32;
	localparam int FRACTION_BITS_DEF = 16;

	// Reset values of the registers, in whole units where fixed point, and the PWM limit
	localparam int SETPOINT_UNITS     = 35;
	localparam int DRIVE_LIMIT_UNITS  = 12;
	localparam int PWM_FULL_SCALE_RST = 885;
	localparam int HORIZON_LEN_RST    = 29;
	localparam int PWM_LIMIT          = 1023;

	// Item kinds
	localparam logic [1:0] KIND_MEAS = 2'd0;
	localparam logic [1:0] KIND_GAIN = 2'd1;
	localparam logic [1:0] KIND_STEP = 2'd2;

	// Register indexes
	localparam logic [2:0] CFG_SETPOINT  = 3'd0;
	localparam logic [2:0] CFG_DRIVE_MAX = 3'd1;
	localparam logic [2:0] CFG_DRIVE_MIN = 3'd2;
	localparam logic [2:0] CFG_PWM_FS    = 3'd3;
	localparam logic [2:0] CFG_HORIZON   = 3'd4;

	localparam logic signed [63:0] S32_MAX_64 = 64'sh0000_0000_7fff_ffff;
	localparam logic signed [63:0] S32_MIN_64 = -64'sh0000_0000_8000_0000;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_START,
		OP_PHI,
		OP_A_UPD,
		OP_A_MUL,
		OP_A_ACC,
		OP_MOVE,
		OP_CLAMP,
		OP_B_MUL,
		OP_B_UPD,
		OP_B_LAST,
		OP_PWM_MUL,
		OP_DIV_INIT,
		OP_DIV_STEP,
		OP_OUT
	} op_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic div_done;
	} stat_t;

	// Saturate a 33-bit sum to 32 bits
	function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
		logic signed [31:0] r;
		if (v[32] != v[31]) begin
			r = v[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== sv/dmc_if.sv =====
// ----------------------------------------------------------------------------
// dmc_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface dmc_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         kind;
	logic [4:0]         index;
	logic signed [31:0] value;

	modport source (output valid, output kind, output index, output value, input ready);
	modport sink (input valid, input kind, input index, input value, output ready);
endinterface

interface dmc_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] drive;
	logic signed [10:0] pwm;
	logic               clamped;

	modport source (output valid, output drive, output pwm, output clamped, input ready);
	modport sink (input valid, input drive, input pwm, input clamped, output ready);
endinterface

`default_nettype wire

// ===== sv/dmc_datapath.sv =====
// ----------------------------------------------------------------------------
// dmc_datapath
// Registers, coefficient and prediction memories, shared multiplier, divider.
// ----------------------------------------------------------------------------
`default_nettype none

module dmc_datapath #(
	parameter int HORIZON_MAX   = dmc_pkg::HORIZON_MAX_DEF,
	parameter int FRACTION_BITS = dmc_pkg::FRACTION_BITS_DEF,
	localparam int IDX_W = $clog2(HORIZON_MAX),
	localparam int LEN_W = $clog2(HORIZON_MAX + 1)
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      cfg_wr_en,
	input  wire [2:0]                cfg_index,
	input  wire [31:0]               cfg_data,
	input  wire [1:0]                in_kind,
	input  wire [4:0]                in_index,
	input  wire signed [31:0]        in_value,
	input  dmc_pkg::cmd_t            cmd,
	input  wire [IDX_W-1:0]          idx,
	output dmc_pkg::stat_t           st,
	output logic [LEN_W-1:0]         len,
	output logic signed [31:0]       out_drive,
	output logic signed [10:0]       out_pwm,
	output logic                     out_clamped
);
	import dmc_pkg::*;

	localparam int ACC_W = 64 - FRACTION_BITS + LEN_W + 1;
	localparam int SW    = 64 - FRACTION_BITS + 1;
	localparam int NUM_W = 42;
	localparam int CNT_W = $clog2(NUM_W + 1);
	localparam logic signed [ACC_W-1:0] ACC_MAX = ACC_W'(S32_MAX_64);
	localparam logic signed [ACC_W-1:0] ACC_MIN = ACC_W'(S32_MIN_64);
	localparam logic signed [SW-1:0]    SW_MAX  = SW'(S32_MAX_64);
	localparam logic signed [SW-1:0]    SW_MIN  = SW'(S32_MIN_64);

	logic signed [31:0] setpoint_q, drive_max_q, drive_min_q;
	logic [9:0]         pwm_fs_q;
	logic [5:0]         horizon_q;

	logic signed [31:0] pred_mem [HORIZON_MAX];
	logic signed [31:0] gain_mem [HORIZON_MAX];
	logic signed [31:0] step_mem [HORIZON_MAX];
	logic [HORIZON_MAX-1:0] pred_vld_q;
	logic signed [31:0] pred_rd_q, gain_rd_q, step_rd_q;
	logic               pred_rd_vld_q;

	logic signed [31:0] value_q, phi_q, e_q, move_q, drive_q, prev_q, first_q;
	logic               clamp_q, neg_q;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [63:0] prod_q;
	logic [NUM_W-1:0]   n_q;
	logic [31:0]        rem_q, dmag_q;
	logic [CNT_W-1:0]   cnt_q;

	logic signed [31:0] pred_rd, p_a, p_b, mul_a, mul_b, move_sat, drive_c, move_c;
	logic signed [SW-1:0] sum_b;
	logic signed [32:0] sum_c;
	logic               clamp_c;
	logic               pwe;
	logic [IDX_W-1:0]   pwaddr;
	logic signed [31:0] pwdata;
	logic               load_ok;
	logic [32:0]        r33;
	logic               q_bit;
	logic [31:0]        rem_n;
	logic signed [NUM_W-1:0] num;
	logic [9:0]         q_sat;

	// Active horizon, clipped to one entry at least and the storage at most
	always_comb begin
		if (horizon_q == '0) begin
			len = LEN_W'(1);
		end else if (32'(horizon_q) > HORIZON_MAX) begin
			len = LEN_W'(HORIZON_MAX);
		end else begin
			len = LEN_W'(horizon_q);
		end
	end

	assign pred_rd = pred_rd_vld_q ? pred_rd_q : 32'sd0;
	assign p_a     = sat33(33'(pred_rd) + 33'(phi_q));
	assign sum_b   = SW'(pred_rd) + SW'(prod_q >>> FRACTION_BITS);
	assign p_b     = (sum_b > SW_MAX) ? 32'sh7fff_ffff :
		(sum_b < SW_MIN) ? 32'sh8000_0000 : sum_b[31:0];
	assign move_sat = (acc_q > ACC_MAX) ? 32'sh7fff_ffff :
		(acc_q < ACC_MIN) ? 32'sh8000_0000 : acc_q[31:0];

	// Clamp against the exact sum of the previous drive and the move
	always_comb begin
		sum_c   = 33'(prev_q) + 33'(move_q);
		clamp_c = 1'b1;
		if (sum_c > 33'(drive_max_q)) begin
			drive_c = drive_max_q;
		end else if (sum_c < 33'(drive_min_q)) begin
			drive_c = drive_min_q;
		end else begin
			drive_c = sum_c[31:0];
			clamp_c = 1'b0;
		end
		move_c = sat33(33'(drive_c) - 33'(prev_q));
	end

	// Shared multiplier operands
	always_comb begin
		unique case (cmd.op)
			OP_A_MUL: begin
				mul_a = gain_rd_q;
				mul_b = e_q;
			end
			OP_B_MUL: begin
				mul_a = step_rd_q;
				mul_b = move_q;
			end
			default: begin
				mul_a = drive_q;
				mul_b = signed'(32'(pwm_fs_q));
			end
		endcase
	end

	// Prediction write port
	always_comb begin
		pwe    = 1'b0;
		pwaddr = idx;
		pwdata = p_a;
		unique case (cmd.op)
			OP_A_UPD: pwe = 1'b1;
			OP_B_UPD: begin
				pwe    = (idx != '0);
				pwaddr = IDX_W'(idx - 1'b1);
				pwdata = p_b;
			end
			OP_B_LAST: begin
				pwe    = 1'b1;
				pwdata = first_q;
			end
			default: pwe = 1'b0;
		endcase
	end

	assign load_ok = (cmd.op == OP_LOAD) && (32'(in_index) < HORIZON_MAX);
	assign num     = prod_q[NUM_W-1:0];

	// Restoring divide step on magnitudes
	assign r33   = {rem_q, n_q[NUM_W-1]};
	assign q_bit = (r33 >= {1'b0, dmag_q});
	assign rem_n = q_bit ? 32'(r33 - {1'b0, dmag_q}) : r33[31:0];
	assign q_sat = (n_q > NUM_W'(PWM_LIMIT)) ? 10'(PWM_LIMIT) : n_q[9:0];

	assign st.div_done = (cnt_q == '0);

	always_ff @(posedge clk) begin
		if (pwe) begin
			pred_mem[pwaddr] <= pwdata;
		end
		if (load_ok && in_kind == KIND_GAIN) begin
			gain_mem[IDX_W'(in_index)] <= in_value;
		end
		if (load_ok && in_kind == KIND_STEP) begin
			step_mem[IDX_W'(in_index)] <= in_value;
		end
		pred_rd_q     <= pred_mem[idx];
		pred_rd_vld_q <= pred_vld_q[idx];
		gain_rd_q     <= gain_mem[idx];
		step_rd_q     <= step_mem[idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pred_vld_q <= '0;
		end else if (pwe) begin
			pred_vld_q[pwaddr] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			setpoint_q  <= 32'(SETPOINT_UNITS) << FRACTION_BITS;
			drive_max_q <= 32'(DRIVE_LIMIT_UNITS) << FRACTION_BITS;
			drive_min_q <= -(32'(DRIVE_LIMIT_UNITS) << FRACTION_BITS);
			pwm_fs_q    <= 10'(PWM_FULL_SCALE_RST);
			horizon_q   <= 6'(HORIZON_LEN_RST);
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_SETPOINT:  setpoint_q  <= cfg_data;
				CFG_DRIVE_MAX: drive_max_q <= cfg_data;
				CFG_DRIVE_MIN: drive_min_q <= cfg_data;
				CFG_PWM_FS:    pwm_fs_q    <= cfg_data[9:0];
				CFG_HORIZON:   horizon_q   <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (cmd.op == OP_B_LAST) begin
				prev_q <= drive_q;
			end
			if (cmd.op == OP_DIV_INIT) begin
				cnt_q <= (drive_max_q == 32'sd0) ? '0 : CNT_W'(NUM_W);
			end else if (cmd.op == OP_DIV_STEP && cnt_q != '0) begin
				cnt_q <= CNT_W'(cnt_q - 1'b1);
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_START: begin
				value_q <= in_value;
				acc_q   <= '0;
			end
			OP_PHI:   phi_q <= sat33(33'(value_q) - 33'(pred_rd));
			OP_A_UPD: e_q <= sat33(33'(setpoint_q) - 33'(p_a));
			OP_A_MUL, OP_B_MUL, OP_PWM_MUL: prod_q <= mul_a * mul_b;
			OP_A_ACC: acc_q <= acc_q + ACC_W'(prod_q >>> FRACTION_BITS);
			OP_MOVE:  move_q <= move_sat;
			OP_CLAMP: begin
				drive_q <= drive_c;
				clamp_q <= clamp_c;
				if (clamp_c) begin
					move_q <= move_c;
				end
			end
			OP_B_UPD: begin
				if (idx == '0) begin
					first_q <= p_b;
				end
			end
			OP_DIV_INIT: begin
				n_q    <= (drive_max_q == 32'sd0) ? '0 :
					(num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num));
				dmag_q <= drive_max_q[31] ? 32'(-drive_max_q) : 32'(drive_max_q);
				neg_q  <= num[NUM_W-1] ^ drive_max_q[31];
				rem_q  <= '0;
			end
			OP_DIV_STEP: begin
				if (cnt_q != '0) begin
					rem_q <= rem_n;
					n_q   <= {n_q[NUM_W-2:0], q_bit};
				end
			end
			OP_OUT: begin
				out_drive   <= drive_q;
				out_clamped <= clamp_q;
				out_pwm     <= neg_q ? -11'(q_sat) : 11'(q_sat);
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

// ===== sv/dmc_ctrl.sv =====
// ----------------------------------------------------------------------------
// dmc_ctrl
// Sequencer for loads and for the two horizon passes of a measurement.
// ----------------------------------------------------------------------------
`default_nettype none
`include "dynamic_matrix_control_step_macros.svh"

module dmc_ctrl #(
	parameter int HORIZON_MAX = dmc_pkg::HORIZON_MAX_DEF,
	localparam int IDX_W = $clog2(HORIZON_MAX),
	localparam int LEN_W = $clog2(HORIZON_MAX + 1)
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	input  wire [1:0]         in_kind,
	output logic              in_ready,
	output logic              out_valid,
	input  wire               out_ready,
	input  dmc_pkg::stat_t    st,
	input  wire [LEN_W-1:0]   len,
	output dmc_pkg::cmd_t     cmd,
	output logic [IDX_W-1:0]  idx
);
	import dmc_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE, S_PHI_RD, S_PHI, S_A_RD, S_A_UPD, S_A_MUL, S_A_ACC, S_MOVE, S_CLAMP,
		S_B_RD, S_B_MUL, S_B_UPD, S_B_LAST, S_PWM_MUL, S_DIV_INIT, S_DIV, S_DONE
	} state_t;

	state_t           state_q;
	logic [LEN_W-1:0] i_q;
	logic             out_valid_q;
	logic             last_c;
	logic             out_free;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign last_c    = (LEN_W'(i_q + 1'b1) == len);
	assign out_free  = !out_valid_q || out_ready;
	assign idx = (state_q == S_B_LAST) ? IDX_W'(len - 1'b1) : i_q[IDX_W-1:0];

	always_comb begin
		unique case (state_q)
			S_IDLE: begin
				if (!in_valid) begin
					cmd.op = OP_NONE;
				end else if (in_kind == KIND_MEAS) begin
					cmd.op = OP_START;
				end else if (in_kind == KIND_GAIN || in_kind == KIND_STEP) begin
					cmd.op = OP_LOAD;
				end else begin
					cmd.op = OP_NONE;
				end
			end
			S_PHI:      cmd.op = OP_PHI;
			S_A_UPD:    cmd.op = OP_A_UPD;
			S_A_MUL:    cmd.op = OP_A_MUL;
			S_A_ACC:    cmd.op = OP_A_ACC;
			S_MOVE:     cmd.op = OP_MOVE;
			S_CLAMP:    cmd.op = OP_CLAMP;
			S_B_MUL:    cmd.op = OP_B_MUL;
			S_B_UPD:    cmd.op = OP_B_UPD;
			S_B_LAST:   cmd.op = OP_B_LAST;
			S_PWM_MUL:  cmd.op = OP_PWM_MUL;
			S_DIV_INIT: cmd.op = OP_DIV_INIT;
			S_DIV:      cmd.op = st.div_done ? OP_NONE : OP_DIV_STEP;
			S_DONE:     cmd.op = out_free ? OP_OUT : OP_NONE;
			default:    cmd.op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			i_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// drop the result once the sink takes it
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					i_q <= '0;
					if (in_valid && in_kind == KIND_MEAS) begin
						state_q <= S_PHI_RD;
					end
				end
				S_PHI_RD: state_q <= S_PHI;
				S_PHI:    state_q <= S_A_RD;
				S_A_RD:   state_q <= S_A_UPD;
				S_A_UPD:  state_q <= S_A_MUL;
				S_A_MUL:  state_q <= S_A_ACC;
				S_A_ACC: begin
					if (last_c) begin
						i_q     <= '0;
						state_q <= S_MOVE;
					end else begin
						i_q     <= LEN_W'(i_q + 1'b1);
						state_q <= S_A_RD;
					end
				end
				S_MOVE:  state_q <= S_CLAMP;
				S_CLAMP: state_q <= S_B_RD;
				S_B_RD:  state_q <= S_B_MUL;
				S_B_MUL: state_q <= S_B_UPD;
				S_B_UPD: begin
					if (last_c) begin
						i_q     <= '0;
						state_q <= S_B_LAST;
					end else begin
						i_q     <= LEN_W'(i_q + 1'b1);
						state_q <= S_B_RD;
					end
				end
				S_B_LAST:   state_q <= S_PWM_MUL;
				S_PWM_MUL:  state_q <= S_DIV_INIT;
				S_DIV_INIT: state_q <= S_DIV;
				S_DIV: begin
					if (st.div_done) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`DMC_ASSERT_NEXT(a_meas_starts, state_q == S_IDLE && in_valid && in_kind == KIND_MEAS,
		state_q == S_PHI_RD, "measurement did not start the offset read")
	`DMC_ASSERT_NOW(a_idx_in_horizon, state_q == S_A_RD || state_q == S_B_RD,
		i_q < len, "horizon index beyond active length")
	`DMC_ASSERT_NEXT(a_result_posted, state_q == S_DONE && out_free,
		out_valid_q && state_q == S_IDLE, "finished result not posted")
	`DMC_ASSERT_NEXT(a_load_stays_idle,
		state_q == S_IDLE && in_valid && in_kind != KIND_MEAS,
		state_q == S_IDLE, "load item left idle")

endmodule

`default_nettype wire

// ===== sv/dynamic_matrix_control_step.sv =====
// ----------------------------------------------------------------------------
// dynamic_matrix_control_step
// Single-input dynamic matrix control step, fixed point, with PWM output.
// ----------------------------------------------------------------------------
//  channel | dir | handshake   | payload
//  req     | in  | valid/ready | kind, index, value
//  rsp     | out | valid/ready | drive, pwm, clamped
//  cfg     | in  | cfg_wr_en   | cfg_index, cfg_data
//
//  A load item is written to its table when it is taken, and the block stays
//  idle. A measurement holds the block until its result is posted: an offset
//  and dot product pass reads, updates, multiplies and accumulates for each
//  active horizon entry, a prediction update pass reads, multiplies and
//  updates for each entry, both on one shared multiplier, and the PWM value
//  comes from a bit-serial divider (no divide steps when drive_max is zero).
//  One item is in work at a time; a posted result holds in the output
//  register while the next item is accepted, and the next result waits for it.
//  Reset clears the predictions (valid bits) and previous drive and loads the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module dynamic_matrix_control_step #(
	parameter int HORIZON_MAX   = dmc_pkg::HORIZON_MAX_DEF,
	parameter int FRACTION_BITS = dmc_pkg::FRACTION_BITS_DEF
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        cfg_wr_en,
	input  wire [2:0]  cfg_index,
	input  wire [31:0] cfg_data,
	dmc_req_if.sink    req,
	dmc_rsp_if.source  rsp
);
	import dmc_pkg::*;

	localparam int IDX_W = $clog2(HORIZON_MAX);
	localparam int LEN_W = $clog2(HORIZON_MAX + 1);

	cmd_t             cmd;
	stat_t            st;
	logic [IDX_W-1:0] idx;
	logic [LEN_W-1:0] len;

	dmc_ctrl #(
		.HORIZON_MAX(HORIZON_MAX)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_kind   (req.kind),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.st        (st),
		.len       (len),
		.cmd       (cmd),
		.idx       (idx)
	);

	dmc_datapath #(
		.HORIZON_MAX  (HORIZON_MAX),
		.FRACTION_BITS(FRACTION_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_kind    (req.kind),
		.in_index   (req.index),
		.in_value   (req.value),
		.cmd        (cmd),
		.idx        (idx),
		.st         (st),
		.len        (len),
		.out_drive  (rsp.drive),
		.out_pwm    (rsp.pwm),
		.out_clamped(rsp.clamped)
	);

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// Testbench for dynamic_matrix_control_step
// Loads the gain and step-response entries, then runs directed and random
// measurements under several register settings with random stalls on both
// channels. Each result is checked against a predictor or a typed script row.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
	import dmc_pkg::*;

	localparam logic [1:0] KIND_IGNORED = 2'd3;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int HOLD_CYCLES = 3000;
	localparam int SETTLE_CYCLES = 20;
	localparam int NUM_PHASES = 6;
	localparam int SCRIPT_LEN = 21;
	localparam int RANDOM_PER_PHASE = 147;

	typedef struct {
		logic signed [31:0] drive;
		logic signed [10:0] pwm;
		logic               clamped;
	} drive_t;

	typedef struct {
		logic [1:0]  kind;
		logic [4:0]  idx;
		logic [31:0] val;
		bit          typed;
		logic [31:0] drive;
		logic [10:0] pwm;
		bit          clamped;
	} row_t;

	typedef struct {
		logic [31:0] setpoint;
		logic [31:0] dmax;
		logic [31:0] dmin;
		logic [9:0]  fs;
		logic [5:0]  hlen;
	} setting_t;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [2:0] cfg_index;
	logic [31:0] cfg_data;

	dmc_req_if req_ch();
	dmc_rsp_if rsp_ch();

	dynamic_matrix_control_step DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	// Predictor state
	logic signed [31:0] m_setpoint, m_dmax, m_dmin;
	logic [9:0] m_fs;
	logic [5:0] m_hlen;
	logic signed [31:0] m_pred [32];
	logic signed [31:0] m_gain [32];
	logic signed [31:0] m_step [32];
	logic signed [31:0] m_prev_drive;

	drive_t pending_drives[$];
	int errors = 0;
	int idle_cycles = 0;
	bit rx_hold_req = 0;
	bit rx_no_stall = 0;
	bit tx_no_gap = 0;

	row_t script [SCRIPT_LEN] = '{
		'{KIND_MEAS, 5'd0, 32'h0000_0000, 1, 32'h0000_0000, 11'd0, 0},
		'{KIND_GAIN, 5'd0, 32'h7fff_ffff, 0, 32'h0, 11'd0, 0},
		'{KIND_MEAS, 5'd0, 32'h0000_0000, 1, 32'h000c_0000, 11'd885, 1},
		'{KIND_GAIN, 5'd0, 32'h8000_0000, 0, 32'h0, 11'd0, 0},
		'{KIND_MEAS, 5'd0, 32'h0000_0000, 1, 32'hfff4_0000, -11'sd885, 1},
		'{KIND_GAIN, 5'd0, 32'h0000_0000, 0, 32'h0, 11'd0, 0},
		'{KIND_STEP, 5'd31, 32'h7fff_ffff, 0, 32'h0, 11'd0, 0},
		'{KIND_STEP, 5'd0, 32'h0001_0000, 0, 32'h0, 11'd0, 0},
		'{KIND_GAIN, 5'd31, 32'h0000_0100, 0, 32'h0, 11'd0, 0},
		'{KIND_IGNORED, 5'd31, 32'hffff_ffff, 0, 32'h0, 11'd0, 0},
		'{KIND_MEAS, 5'd0, 32'h7fff_ffff, 0, 32'h0, 11'd0, 0},
		'{KIND_MEAS, 5'd31, 32'h8000_0000, 0, 32'h0, 11'd0, 0},
		'{KIND_MEAS, 5'd0, 32'h0023_0000, 0, 32'h0, 11'd0, 0},
		'{KIND_GAIN, 5'd5, 32'hffff_0000, 0, 32'h0, 11'd0, 0},
		'{KIND_MEAS, 5'd0, 32'h0020_0000, 0, 32'h0, 11'd0, 0},
		'{KIND_STEP, 5'd17, 32'h5555_5555, 0, 32'h0, 11'd0, 0},
		'{KIND_GAIN, 5'd10, 32'haaaa_aaaa, 0, 32'h0, 11'd0, 0},
		'{KIND_MEAS, 5'd0, 32'h0024_0000, 0, 32'h0, 11'd0, 0},
		'{KIND_GAIN, 5'd10, 32'h0000_0000, 0, 32'h0, 11'd0, 0},
		'{KIND_STEP, 5'd17, 32'h0000_0000, 0, 32'h0, 11'd0, 0},
		'{KIND_MEAS, 5'd0, 32'h0023_8000, 0, 32'h0, 11'd0, 0}
	};

	setting_t settings [NUM_PHASES] = '{
		'{32'h0023_0000, 32'h000c_0000, 32'hfff4_0000, 10'd885, 6'd29},
		'{32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 10'd1023, 6'd32},
		'{32'h8000_0000, 32'h0000_0000, 32'hfff4_0000, 10'd0, 6'd1},
		'{32'h0000_0000, 32'hffff_0000, 32'h0001_0000, 10'd512, 6'd0},
		'{32'h0023_0000, 32'h8000_0000, 32'h7fff_ffff, 10'd700, 6'd63},
		'{32'h0010_0000, 32'h0014_0000, 32'hffec_0000, 10'd1, 6'd7}
	};

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function automatic logic signed [31:0] sat32(input longint v);
		if (v > 64'sh7fff_ffff) return 32'sh7fff_ffff;
		if (v < -64'sh8000_0000) return 32'sh8000_0000;
		return v[31:0];
	endfunction

	function automatic longint fx_product(input logic signed [31:0] a,
			input logic signed [31:0] b);
		longint p;
		p = longint'(a) * longint'(b);
		return p >>> FRACTION_BITS_DEF;
	endfunction

	// Advance the control state by one measurement and return its drive.
	function automatic drive_t control_step(input logic signed [31:0] meas);
		drive_t r;
		int len;
		logic signed [31:0] offset, move, first;
		longint acc, total, pwm;
		len = (m_hlen == 0) ? 1 : (m_hlen > 32) ? 32 : int'(m_hlen);
		offset = sat32(longint'(meas) - longint'(m_pred[0]));
		for (int i = 0; i < len; i++) m_pred[i] = sat32(longint'(m_pred[i]) + offset);
		acc = 0;
		for (int i = 0; i < len; i++)
			acc += fx_product(m_gain[i], sat32(longint'(m_setpoint) - longint'(m_pred[i])));
		move = sat32(acc);
		total = longint'(m_prev_drive) + longint'(move);
		r.clamped = 1;
		if (total > longint'(m_dmax)) r.drive = m_dmax;
		else if (total < longint'(m_dmin)) r.drive = m_dmin;
		else begin
			r.drive = total[31:0];
			r.clamped = 0;
		end
		if (r.clamped) move = sat32(longint'(r.drive) - longint'(m_prev_drive));
		for (int i = 0; i < len; i++)
			m_pred[i] = sat32(longint'(m_pred[i]) + fx_product(m_step[i], move));
		first = m_pred[0];
		for (int i = 1; i < len; i++) m_pred[i - 1] = m_pred[i];
		m_pred[len - 1] = first;
		m_prev_drive = r.drive;
		if (m_dmax == 0) pwm = 0;
		else begin
			pwm = (longint'(r.drive) * longint'({1'b0, m_fs})) / longint'(m_dmax);
			if (pwm > PWM_LIMIT) pwm = PWM_LIMIT;
			if (pwm < -PWM_LIMIT) pwm = -PWM_LIMIT;
		end
		r.pwm = pwm[10:0];
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 20);
		return $urandom_range(50, 300);
	endfunction

	task automatic report(input string field, input longint got, input longint want);
		errors++;
		if (errors <= 50) $display("%0t mismatch on %s: got %0d, expected %0d", $time, field, got, want);
	endtask

	task automatic send_item(input logic [1:0] kind, input logic [4:0] idx,
			input logic [31:0] val, input bit typed, input drive_t typed_drive);
		drive_t d;
		int g;
		req_ch.valid <= 1;
		req_ch.kind <= kind;
		req_ch.index <= idx;
		req_ch.value <= val;
		do @(posedge clk); while (!req_ch.ready);
		case (kind)
			KIND_GAIN: m_gain[idx] = val;
			KIND_STEP: m_step[idx] = val;
			KIND_MEAS: begin
				d = control_step(val);
				pending_drives.insert(pending_drives.size(), typed ? typed_drive : d);
			end
			default: ;
		endcase
		g = tx_no_gap ? 0 : pick_gap();
		if (g > 0) begin
			req_ch.valid <= 0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic drain();
		req_ch.valid <= 0;
		while (pending_drives.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
		cfg_wr_en <= 1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		case (idx)
			CFG_SETPOINT:  m_setpoint = data;
			CFG_DRIVE_MAX: m_dmax = data;
			CFG_DRIVE_MIN: m_dmin = data;
			CFG_PWM_FS:    m_fs = data[9:0];
			CFG_HORIZON:   m_hlen = data[5:0];
			default: ;
		endcase
	endtask

	function automatic logic [31:0] coef_value(input bit is_gain);
		int r;
		r = $urandom_range(0, 99);
		if (r < 8) return $urandom;
		if (is_gain) return 32'($urandom_range(0, 16384)) - 32'd8192;
		return 32'($urandom_range(0, 131072)) - 32'd65536;
	endfunction

	function automatic logic [31:0] meas_value();
		if ($urandom_range(0, 99) < 10) return $urandom;
		return m_setpoint + 32'($urandom_range(0, 2097152)) - 32'd1048576;
	endfunction

	// Result side: check each transfer, stall at random
	initial begin
		int stall;
		drive_t want;
		stall = 0;
		rsp_ch.ready = 0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
				if (pending_drives.size() == 0) report("unexpected result", rsp_ch.drive, 0);
				else begin
					want = pending_drives.pop_front();
					if (rsp_ch.drive !== want.drive) report("drive", rsp_ch.drive, want.drive);
					if (rsp_ch.pwm !== want.pwm) report("pwm", rsp_ch.pwm, want.pwm);
					if (rsp_ch.clamped !== want.clamped)
						report("clamped", rsp_ch.clamped, want.clamped);
				end
			end
			if (rx_hold_req) begin
				rsp_ch.ready <= 0;
				rx_hold_req = 0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (stall > 0) begin
				rsp_ch.ready <= 0;
				stall--;
			end else begin
				rsp_ch.ready <= 1;
				if (!rx_no_stall) stall = pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("dynamic_matrix_control_step verification failed");
			$finish;
		end
	end

	initial begin
		drive_t typed_drive, none;
		logic [1:0] kind;
		int r;
		none = '{0, 0, 0};
		arst_n = 0;
		cfg_wr_en = 0;
		cfg_index = CFG_SETPOINT;
		cfg_data = 0;
		req_ch.valid = 0;
		req_ch.kind = KIND_MEAS;
		req_ch.index = 0;
		req_ch.value = 0;
		m_setpoint = SETPOINT_UNITS <<< FRACTION_BITS_DEF;
		m_dmax = DRIVE_LIMIT_UNITS <<< FRACTION_BITS_DEF;
		m_dmin = -(DRIVE_LIMIT_UNITS <<< FRACTION_BITS_DEF);
		m_fs = 10'(PWM_FULL_SCALE_RST);
		m_hlen = 6'(HORIZON_LEN_RST);
		m_prev_drive = 0;
		for (int i = 0; i < 32; i++) begin
			m_pred[i] = 0;
			m_gain[i] = 0;
			m_step[i] = 0;
		end
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Every coefficient is written before any measurement reads it
		for (int i = 0; i < 32; i++) begin
			send_item(KIND_GAIN, i[4:0], 32'h0, 0, none);
			send_item(KIND_STEP, i[4:0], 32'h0, 0, none);
		end
		foreach (script[i]) begin
			typed_drive = '{script[i].drive, script[i].pwm, script[i].clamped};
			send_item(script[i].kind, script[i].idx, script[i].val, script[i].typed, typed_drive);
		end

		for (int p = 0; p < NUM_PHASES; p++) begin
			drain();
			write_reg(CFG_SETPOINT, settings[p].setpoint);
			write_reg(CFG_DRIVE_MAX, settings[p].dmax);
			write_reg(CFG_DRIVE_MIN, settings[p].dmin);
			write_reg(CFG_PWM_FS, {22'($urandom), settings[p].fs});
			write_reg(CFG_HORIZON, {26'($urandom), settings[p].hlen});
			cfg_wr_en <= 0;
			tx_no_gap = (p == 1 || p == NUM_PHASES - 1);
			rx_no_stall = (p == NUM_PHASES - 1);
			// Refresh the gain and step coefficients with random values, mostly small
			for (int i = 0; i < 32; i++) begin
				send_item(KIND_GAIN, i[4:0], coef_value(1), 0, none);
				send_item(KIND_STEP, i[4:0], coef_value(0), 0, none);
			end
			for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
				if (p == 1 && n == 40) rx_hold_req = 1;
				if (p == 2 && n == 100) drain();
				r = $urandom_range(0, 99);
				kind = (r < 60) ? KIND_MEAS : (r < 78) ? KIND_GAIN :
					(r < 96) ? KIND_STEP : KIND_IGNORED;
				if (kind == KIND_MEAS || kind == KIND_IGNORED)
					send_item(kind, 5'($urandom), meas_value(), 0, none);
				else
					send_item(kind, 5'($urandom), coef_value(kind == KIND_GAIN), 0, none);
			end
		end

		drain();
		repeat (400) @(posedge clk);
		if (errors == 0 && pending_drives.size() == 0)
			$display("dynamic_matrix_control_step verification clean");
		else
			$display("dynamic_matrix_control_step verification failed");
		$finish;
	end

endmodule
